@@ design/quad_mesh_panel_geometry_macros.svh @@
// Assertion helpers, clocked on clk_i, idle while rst_ni is low.
`ifndef QUAD_MESH_PANEL_GEOMETRY_MACROS_SVH
`define QUAD_MESH_PANEL_GEOMETRY_MACROS_SVH

// same-cycle implication
`define QMPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qmpg assertion failed");

// next-cycle implication
`define QMPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qmpg assertion failed");

`endif

@@ design/qmpg_pkg.sv @@
package qmpg_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIFF_W  = 25;
  localparam int unsigned MUL_W   = 27;
  localparam int unsigned PROD_W  = 54;
  localparam int unsigned CROSS_W = 51;
  localparam int unsigned MAG_W   = 50;
  localparam int unsigned SQ_W    = 100;
  localparam int unsigned ROOT_W  = 50;
  localparam int unsigned REM_W   = 52;
  localparam int unsigned DIV_W   = 66;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned AREA_W  = 49;
  localparam int unsigned TOTAL_W = 63;
  localparam int unsigned PPL_W   = 11;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CFG_W   = 49;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SQRT_STEPS = SQ_W / 2;
  localparam int unsigned DIV_STEPS  = QUO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_NORMALS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_THRESHOLD  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      mesh_start;
  } point_t;

  typedef struct packed {
    logic [9:0]                panel_row;
    logic [9:0]                panel_col;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic signed [COORD_W-1:0] centroid_z;
    logic signed [15:0]        normal_x;
    logic signed [15:0]        normal_y;
    logic signed [15:0]        normal_z;
    logic [AREA_W-1:0]         panel_area;
    logic [TOTAL_W-1:0]        total_area;
    logic                      degenerate;
  } panel_t;

  typedef struct packed {
    logic       accept;
    logic       rd_a;
    logic       rd_b;
    logic       cap_a;
    logic       cap_b;
    logic       diff;
    logic       wr_a;
    logic       wr_b;
    logic       mul;
    logic       sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       area;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       fin;
    logic [1:0] comp;
    logic [1:0] sub;
  } cmd_t;

  typedef struct packed {
    logic panel;
    logic zero;
    logic out_busy;
  } status_t;

endpackage

@@ design/qmpg_if.sv @@
interface qmpg_point_if;
  logic              valid;
  logic              ready;
  qmpg_pkg::point_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qmpg_panel_if;
  logic              valid;
  logic              ready;
  qmpg_pkg::panel_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/qmpg_ram.sv @@
module qmpg_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/qmpg_ctrl.sv @@
module qmpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmpg_pkg::status_t status_i,
  output qmpg_pkg::cmd_t    cmd_o
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDA   = 4'd1;
  localparam logic [3:0] ST_RDB   = 4'd2;
  localparam logic [3:0] ST_CAP   = 4'd3;
  localparam logic [3:0] ST_DIFF  = 4'd4;
  localparam logic [3:0] ST_WRA   = 4'd5;
  localparam logic [3:0] ST_WRB   = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_SQ    = 4'd8;
  localparam logic [3:0] ST_SQI   = 4'd9;
  localparam logic [3:0] ST_SQRT  = 4'd10;
  localparam logic [3:0] ST_AREA  = 4'd11;
  localparam logic [3:0] ST_DINIT = 4'd12;
  localparam logic [3:0] ST_DIV   = 4'd13;
  localparam logic [3:0] ST_DFIN  = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic [1:0] sub_q, sub_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    sub_d   = sub_q;
    cmd_o   = '0;
    cmd_o.comp = comp_q;
    cmd_o.sub  = sub_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_RDA;
        end
      end
      ST_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rd_b  = 1'b1;
        cmd_o.cap_a = 1'b1;
        state_d = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.cap_b = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = ST_WRA;
      end
      ST_WRA: begin
        cmd_o.wr_a = 1'b1;
        state_d = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.wr_b = 1'b1;
        comp_d = 2'd0;
        sub_d  = 2'd0;
        state_d = status_i.panel ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (sub_q == 2'd2) begin
          sub_d = 2'd0;
          if (comp_q == 2'd2) begin
            comp_d  = 2'd0;
            state_d = ST_SQ;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        if (sub_q == 2'd2) begin
          sub_d = 2'd0;
          if (comp_q == 2'd2) begin
            comp_d  = 2'd0;
            state_d = ST_SQI;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      ST_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(qmpg_pkg::SQRT_STEPS - 1)) begin
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd_o.area = 1'b1;
        comp_d  = 2'd0;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        // zero flag is registered by the area step in the state just before
        if (status_i.zero) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(qmpg_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        cmd_o.div_fin = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_DINIT;
        end
      end
      ST_FIN: begin
        if (!(status_i.panel && status_i.out_busy)) begin
          cmd_o.fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      sub_q   <= sub_d;
    end
  end
endmodule

@@ design/qmpg_dp.sv @@
module qmpg_dp #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_LINES  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qmpg_pkg::cmd_t                      cmd_i,
  output qmpg_pkg::status_t                   status_o,
  input  qmpg_pkg::point_t                    in_data_i,
  input  logic [qmpg_pkg::PPL_W-1:0]          ppl_i,
  input  logic                                rev_i,
  input  logic [qmpg_pkg::AREA_W-1:0]         thr_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output qmpg_pkg::panel_t                    out_data_o
);
  localparam int unsigned CW = $clog2(MAX_POINTS);
  localparam int unsigned LW = $clog2(MAX_LINES);
  localparam int unsigned PW = qmpg_pkg::LEN_W;
  localparam int unsigned XW = 3 * qmpg_pkg::COORD_W;

  qmpg_pkg::coord_t cur_q, prev_q, a_q, b_q;
  logic [CW-1:0] col_q;
  logic [LW-1:0] line_q;
  logic [qmpg_pkg::TOTAL_W-1:0] sum_q;

  logic signed [qmpg_pkg::DIFF_W-1:0] d1_q [3];
  logic signed [qmpg_pkg::DIFF_W-1:0] d2_q [3];
  logic signed [qmpg_pkg::COORD_W-1:0] cen_q [3];
  logic signed [qmpg_pkg::CROSS_W-1:0] acc_q;
  logic signed [qmpg_pkg::CROSS_W-1:0] cr_q [3];
  logic [qmpg_pkg::MAG_W-1:0] mag_q [3];
  logic neg_q [3];
  logic [qmpg_pkg::SQ_W-1:0] s_q, rad_q;
  logic [qmpg_pkg::REM_W-1:0] srem_q;
  logic [qmpg_pkg::ROOT_W-1:0] root_q;
  logic [qmpg_pkg::AREA_W-1:0] area_q;
  logic degen_q, zero_q;
  logic [qmpg_pkg::DIV_W-1:0] drem_q, dv_q;
  logic [qmpg_pkg::QUO_W-1:0] quo_q;
  logic signed [15:0] nrm_q [3];
  qmpg_pkg::panel_t out_q;
  logic out_valid_q;

  // line length, clamped
  logic [PW-1:0] len_ext, plen, col_next;
  logic end_line, has_panel;
  always_comb begin
    len_ext = PW'(ppl_i);
    if (len_ext < PW'(2)) begin
      plen = PW'(2);
    end else if (len_ext > PW'(MAX_POINTS)) begin
      plen = PW'(MAX_POINTS);
    end else begin
      plen = len_ext;
    end
    col_next = PW'(col_q) + PW'(1);
    end_line = (col_next >= plen);
  end
  assign has_panel = (col_q != '0) && (line_q != '0);

  // line buffer
  logic [CW-1:0] col_m1;
  logic ram_we;
  logic [CW-1:0] ram_waddr;
  logic [XW-1:0] ram_wdata, ram_rdata;
  assign col_m1    = col_q - CW'(1);
  assign ram_we    = (cmd_i.wr_a && col_q != '0) || (cmd_i.wr_b && end_line);
  assign ram_waddr = cmd_i.wr_a ? col_m1 : col_q;
  assign ram_wdata = cmd_i.wr_a ? XW'(prev_q) : XW'(cur_q);

  qmpg_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_a || cmd_i.rd_b),
    .raddr_i (cmd_i.rd_a ? col_m1 : col_q),
    .rdata_o (ram_rdata)
  );

  // shared multiplier: cross terms, then square partials
  logic [1:0] pi, qi;
  logic signed [qmpg_pkg::MUL_W-1:0] ma, mb;
  logic signed [qmpg_pkg::PROD_W-1:0] prod;
  logic [qmpg_pkg::MAG_W-1:0] mcur;
  logic [qmpg_pkg::MUL_W-2:0] mhi, mlo;
  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin pi = 2'd1; qi = 2'd2; end
      2'd1:    begin pi = 2'd2; qi = 2'd0; end
      default: begin pi = 2'd0; qi = 2'd1; end
    endcase
    mcur = mag_q[cmd_i.comp];
    mhi  = (qmpg_pkg::MUL_W-1)'(mcur[qmpg_pkg::MAG_W-1:26]);
    mlo  = mcur[25:0];
    if (cmd_i.sq) begin
      case (cmd_i.sub)
        2'd0:    begin ma = {1'b0, mlo}; mb = {1'b0, mlo}; end
        2'd1:    begin ma = {1'b0, mhi}; mb = {1'b0, mlo}; end
        default: begin ma = {1'b0, mhi}; mb = {1'b0, mhi}; end
      endcase
    end else if (cmd_i.sub == 2'd0) begin
      ma = qmpg_pkg::MUL_W'(d1_q[pi]);
      mb = qmpg_pkg::MUL_W'(d2_q[qi]);
    end else begin
      ma = qmpg_pkg::MUL_W'(d1_q[qi]);
      mb = qmpg_pkg::MUL_W'(d2_q[pi]);
    end
    prod = ma * mb;
  end

  logic [qmpg_pkg::SQ_W-1:0] sq_add;
  always_comb begin
    case (cmd_i.sub)
      2'd0:    sq_add = qmpg_pkg::SQ_W'(prod[51:0]);
      2'd1:    sq_add = qmpg_pkg::SQ_W'(prod[51:0]) << 27;
      default: sq_add = qmpg_pkg::SQ_W'(prod[51:0]) << 52;
    endcase
  end

  // square root step
  logic [qmpg_pkg::REM_W-1:0] r2, trial;
  assign r2    = {srem_q[qmpg_pkg::REM_W-3:0], rad_q[qmpg_pkg::SQ_W-1 -: 2]};
  assign trial = {root_q, 2'b01};

  // saturating total
  logic [qmpg_pkg::TOTAL_W:0] sum_ext;
  logic [qmpg_pkg::AREA_W-1:0] area_n;
  assign area_n  = root_q[qmpg_pkg::ROOT_W-1:1];
  assign sum_ext = {1'b0, sum_q} + (qmpg_pkg::TOTAL_W+1)'(area_n);

  // normal component finish
  logic [14:0] nmag;
  logic nneg;
  assign nmag = (quo_q > qmpg_pkg::QUO_W'(32767)) ? 15'h7FFF : quo_q[14:0];
  assign nneg = neg_q[cmd_i.comp] ^ rev_i;

  // centroid
  logic signed [25:0] csum [3];
  always_comb begin
    csum[0] = 26'(a_q.x) + 26'(b_q.x) + 26'(prev_q.x) + 26'(cur_q.x) + 26'sd2;
    csum[1] = 26'(a_q.y) + 26'(b_q.y) + 26'(prev_q.y) + 26'(cur_q.y) + 26'sd2;
    csum[2] = 26'(a_q.z) + 26'(b_q.z) + 26'(prev_q.z) + 26'(cur_q.z) + 26'sd2;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q <= {in_data_i.point_x, in_data_i.point_y, in_data_i.point_z};
    end
    if (cmd_i.cap_a) a_q <= ram_rdata;
    if (cmd_i.cap_b) b_q <= ram_rdata;
    if (cmd_i.diff) begin
      d1_q[0] <= qmpg_pkg::DIFF_W'(cur_q.x) - qmpg_pkg::DIFF_W'(a_q.x);
      d1_q[1] <= qmpg_pkg::DIFF_W'(cur_q.y) - qmpg_pkg::DIFF_W'(a_q.y);
      d1_q[2] <= qmpg_pkg::DIFF_W'(cur_q.z) - qmpg_pkg::DIFF_W'(a_q.z);
      d2_q[0] <= qmpg_pkg::DIFF_W'(prev_q.x) - qmpg_pkg::DIFF_W'(b_q.x);
      d2_q[1] <= qmpg_pkg::DIFF_W'(prev_q.y) - qmpg_pkg::DIFF_W'(b_q.y);
      d2_q[2] <= qmpg_pkg::DIFF_W'(prev_q.z) - qmpg_pkg::DIFF_W'(b_q.z);
      for (int k = 0; k < 3; k++) begin
        cen_q[k] <= qmpg_pkg::COORD_W'(csum[k] >>> 2);
      end
    end
    if (cmd_i.mul) begin
      case (cmd_i.sub)
        2'd0: acc_q <= qmpg_pkg::CROSS_W'(prod);
        2'd1: cr_q[cmd_i.comp] <= acc_q - qmpg_pkg::CROSS_W'(prod);
        default: begin
          neg_q[cmd_i.comp] <= cr_q[cmd_i.comp][qmpg_pkg::CROSS_W-1];
          mag_q[cmd_i.comp] <= cr_q[cmd_i.comp][qmpg_pkg::CROSS_W-1]
                               ? qmpg_pkg::MAG_W'(-cr_q[cmd_i.comp])
                               : qmpg_pkg::MAG_W'(cr_q[cmd_i.comp]);
        end
      endcase
      s_q <= '0;
    end
    if (cmd_i.sq) s_q <= s_q + sq_add;
    if (cmd_i.sqrt_init) begin
      rad_q  <= s_q;
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (r2 >= trial) begin
        srem_q <= r2 - trial;
        root_q <= {root_q[qmpg_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= r2;
        root_q <= {root_q[qmpg_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.area) begin
      area_q  <= area_n;
      degen_q <= area_n < thr_i;
      zero_q  <= (area_n < thr_i) || (root_q == '0);
      for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
    end
    if (cmd_i.div_init) begin
      drem_q <= (qmpg_pkg::DIV_W'(mag_q[cmd_i.comp]) << 15)
                + qmpg_pkg::DIV_W'(root_q[qmpg_pkg::ROOT_W-1:1]);
      dv_q   <= qmpg_pkg::DIV_W'(root_q) << 16;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      dv_q <= dv_q >> 1;
      if (drem_q >= dv_q) begin
        drem_q <= drem_q - dv_q;
        quo_q  <= {quo_q[qmpg_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_q  <= {quo_q[qmpg_pkg::QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      nrm_q[cmd_i.comp] <= nneg ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
    end
    if (cmd_i.fin && has_panel) begin
      out_q.panel_row  <= 10'(line_q - LW'(1));
      out_q.panel_col  <= 10'(col_m1);
      out_q.centroid_x <= cen_q[0];
      out_q.centroid_y <= cen_q[1];
      out_q.centroid_z <= cen_q[2];
      out_q.normal_x   <= nrm_q[0];
      out_q.normal_y   <= nrm_q[1];
      out_q.normal_z   <= nrm_q[2];
      out_q.panel_area <= area_q;
      out_q.total_area <= sum_q;
      out_q.degenerate <= degen_q;
    end
  end

  // control-side state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      col_q       <= '0;
      line_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && in_data_i.mesh_start) begin
        col_q  <= '0;
        line_q <= '0;
        sum_q  <= '0;
      end
      if (cmd_i.area) begin
        sum_q <= sum_ext[qmpg_pkg::TOTAL_W] ? '1 : sum_ext[qmpg_pkg::TOTAL_W-1:0];
      end
      if (cmd_i.fin) begin
        prev_q <= cur_q;
        if (end_line) begin
          col_q <= '0;
          if (line_q < LW'(MAX_LINES - 1)) line_q <= line_q + LW'(1);
        end else begin
          col_q <= CW'(col_next);
        end
      end
      if (cmd_i.fin && has_panel) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.panel    = has_panel;
  assign status_o.zero     = zero_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ design/quad_mesh_panel_geometry.sv @@
// Quad mesh panel geometry.
// in_if carries one mesh point per beat (Q12.12 x/y/z plus mesh_start),
// row by row. Every point past the first row and column closes a panel, and
// out_if then carries one beat: centroid, unit normal (Q1.15), area (Q24),
// running total area and a degenerate flag. Other points give no beat.
// Config: cfg_we_i writes register cfg_idx_i (0 line length, 1 normal
// reversal, 2 area threshold) from cfg_data_i; write only while idle.
// One point at a time. A panel runs the shared 27x27 multiplier for the
// cross product, then again for its squared norm, then the bit-pair
// square root, then three restoring divides. Degenerate or zero panels
// skip the divides. The two line-buffer corners are read one after the
// other from one RAM port.
// The result sits in an output register; if the sink stalls, the block
// finishes the next panel and then holds until that register frees up.
// Reset clears counters, previous point, total area and restores config
// defaults; the line buffer itself is not cleared.
module quad_mesh_panel_geometry #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_LINES  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  qmpg_point_if.sink                         in_if,
  qmpg_panel_if.source                       out_if,
  input  logic                               cfg_we_i,
  input  logic [qmpg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qmpg_pkg::CFG_W-1:0]         cfg_data_i
);
  `include "quad_mesh_panel_geometry_macros.svh"

  logic [qmpg_pkg::PPL_W-1:0]  ppl_q;
  logic                        rev_q;
  logic [qmpg_pkg::AREA_W-1:0] thr_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q <= qmpg_pkg::PPL_W'(2);
      rev_q <= 1'b0;
      thr_q <= qmpg_pkg::AREA_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qmpg_pkg::CFG_POINTS_PER_LINE: ppl_q <= cfg_data_i[qmpg_pkg::PPL_W-1:0];
        qmpg_pkg::CFG_REVERSE_NORMALS: rev_q <= cfg_data_i[0];
        qmpg_pkg::CFG_AREA_THRESHOLD:  thr_q <= cfg_data_i[qmpg_pkg::AREA_W-1:0];
        default: ;
      endcase
    end
  end

  qmpg_pkg::cmd_t    cmd;
  qmpg_pkg::status_t status;

  qmpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qmpg_dp #(.MAX_POINTS(MAX_POINTS), .MAX_LINES(MAX_LINES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_if.data),
    .ppl_i       (ppl_q),
    .rev_i       (rev_q),
    .thr_i       (thr_q),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

  // one point in flight: no second accept right after the first
  `QMPG_ASSERT_NEXT(a_one_in_flight, in_if.valid && in_if.ready, !in_if.ready)
  // a degenerate panel carries a zero normal
  `QMPG_ASSERT_IMP(a_degen_zero, out_if.valid && out_if.data.degenerate, out_if.data.normal_x == 16'sd0 && out_if.data.normal_y == 16'sd0 && out_if.data.normal_z == 16'sd0)
  // the running total already includes this panel
  `QMPG_ASSERT_IMP(a_total_covers, out_if.valid, out_if.data.total_area >= 63'(out_if.data.panel_area))
endmodule

@@ verif/quad_mesh_panel_geometry_test.sv @@
module quad_mesh_panel_geometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_PTS  = 1024;
  localparam int unsigned LINE_MAX  = 1024;
  localparam longint      CYCLE_CAP = 6000000;
  localparam int          ITEM_GOAL = 950;

  localparam logic [63:0] AREA_MAX  = (64'd1 << qmpg_pkg::AREA_W) - 1;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << qmpg_pkg::TOTAL_W) - 1;

  // stimulus flavors for one mesh
  typedef enum int {MESH_RANDOM, MESH_GRID, MESH_POINT} mesh_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                           cfg_we_i;
  logic [qmpg_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [qmpg_pkg::CFG_W-1:0]     cfg_data_i;

  qmpg_point_if in_if ();
  qmpg_panel_if out_if ();

  quad_mesh_panel_geometry dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // points waiting for the driver, panels waiting for the DUT
  qmpg_pkg::point_t point_queue[$];
  qmpg_pkg::panel_t panel_queue[$];

  int     fail_count = 0;
  int     send_gap   = 0;
  int     recv_gap   = 0;
  int     queued     = 0;     // points handed to the driver so far
  bit     calm       = 1'b0;  // no idling on either side while set
  longint cycle_count = 0;

  // shadow of the mesh state inside the block
  longint      row_x[LINE_PTS];
  longint      row_y[LINE_PTS];
  longint      row_z[LINE_PTS];
  longint      prev_x, prev_y, prev_z;
  int unsigned col_cnt, line_cnt;
  logic [63:0] area_total;

  // shadow of the registers
  logic [10:0] line_len;
  logic        flip_normals;
  logic [63:0] min_area;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [23:0] centroid_of(longint a, longint b, longint c, longint d);
    longint t;
    t = (a + b + c + d + 2) >>> 2;
    return t[23:0];
  endfunction

  function automatic logic [15:0] normal_of(longint ck, logic [63:0] n, bit zero);
    logic [127:0] num, q;
    logic [63:0]  mag;
    logic [15:0]  m16;
    bit           neg;
    if (zero) return 16'd0;
    neg = ck < 0;
    mag = neg ? -ck : ck;
    num = ({64'd0, mag} << 15) + {65'd0, n[63:1]};
    q = num / {64'd0, n};
    m16 = (q > 128'd32767) ? 16'd32767 : q[15:0];
    if (flip_normals) neg = !neg;
    return neg ? -m16 : m16;
  endfunction

  // one accepted point: update the shadow state, queue a panel if one closes
  function automatic void take_point(qmpg_pkg::point_t p);
    longint           cx, cy, cz, ax, ay, az, bx, by, bz;
    longint           d1x, d1y, d1z, d2x, d2y, d2z, crx, cry, crz, mx, my, mz;
    longint           px, py, pz;
    logic [127:0]     sq, cand2;
    logic [63:0]      root, cand, area;
    int unsigned      plen, c;
    bit               degen, zero;
    qmpg_pkg::panel_t pan;
    cx = longint'(p.point_x);
    cy = longint'(p.point_y);
    cz = longint'(p.point_z);
    if (p.mesh_start) begin
      col_cnt = 0;
      line_cnt = 0;
      area_total = 0;
    end
    plen = line_len;
    if (plen < 2) plen = 2;
    if (plen > LINE_PTS) plen = LINE_PTS;
    c = col_cnt;
    if (c >= LINE_PTS) c = 0;
    if (c > 0) begin
      if (line_cnt > 0) begin
        ax = row_x[c-1]; ay = row_y[c-1]; az = row_z[c-1];
        bx = row_x[c];   by = row_y[c];   bz = row_z[c];
        d1x = cx - ax; d1y = cy - ay; d1z = cz - az;
        d2x = prev_x - bx; d2y = prev_y - by; d2z = prev_z - bz;
        crx = d1y * d2z - d1z * d2y;
        cry = d1z * d2x - d1x * d2z;
        crz = d1x * d2y - d1y * d2x;
        mx = crx < 0 ? -crx : crx;
        my = cry < 0 ? -cry : cry;
        mz = crz < 0 ? -crz : crz;
        sq = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
           + {64'd0, mz} * {64'd0, mz};
        // bitwise integer root of the squared norm
        root = 0;
        for (int b = 52; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          cand2 = {64'd0, cand} * {64'd0, cand};
          if (cand2 <= sq) root = cand;
        end
        area = root >> 1;
        if (area > AREA_MAX) area = AREA_MAX;
        degen = area < min_area;
        zero = degen || root == 0;
        area_total = (area_total > TOTAL_MAX - area) ? TOTAL_MAX : area_total + area;
        pan.panel_row  = 10'(line_cnt - 1);
        pan.panel_col  = 10'(c - 1);
        pan.centroid_x = centroid_of(ax, bx, prev_x, cx);
        pan.centroid_y = centroid_of(ay, by, prev_y, cy);
        pan.centroid_z = centroid_of(az, bz, prev_z, cz);
        pan.normal_x   = normal_of(crx, root, zero);
        pan.normal_y   = normal_of(cry, root, zero);
        pan.normal_z   = normal_of(crz, root, zero);
        pan.panel_area = area[qmpg_pkg::AREA_W-1:0];
        pan.total_area = area_total[qmpg_pkg::TOTAL_W-1:0];
        pan.degenerate = degen;
        panel_queue.push_back(pan);
      end
      row_x[c-1] = prev_x; row_y[c-1] = prev_y; row_z[c-1] = prev_z;
    end
    if (c + 1 >= plen) begin
      row_x[c] = cx; row_y[c] = cy; row_z[c] = cz;
    end
    prev_x = cx; prev_y = cy; prev_z = cz;
    if (c + 1 >= plen) begin
      col_cnt = 0;
      if (line_cnt < LINE_MAX - 1) line_cnt++;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // driver: one beat from point_queue whenever the slot is free and no gap runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        in_if.data  <= point_queue.pop_front();
        in_if.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // sink backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  // monitor: check panel beats, then predict from the point beat of this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (panel_queue.size() == 0) begin
          report("unexpected panel", 64'(out_if.data.panel_col), 64'd0);
        end else begin
          qmpg_pkg::panel_t w;
          w = panel_queue.pop_front();
          if (out_if.data.panel_row != w.panel_row)
            report("panel_row", 64'(out_if.data.panel_row), 64'(w.panel_row));
          if (out_if.data.panel_col != w.panel_col)
            report("panel_col", 64'(out_if.data.panel_col), 64'(w.panel_col));
          if (out_if.data.centroid_x != w.centroid_x)
            report("centroid_x", 64'(out_if.data.centroid_x), 64'(w.centroid_x));
          if (out_if.data.centroid_y != w.centroid_y)
            report("centroid_y", 64'(out_if.data.centroid_y), 64'(w.centroid_y));
          if (out_if.data.centroid_z != w.centroid_z)
            report("centroid_z", 64'(out_if.data.centroid_z), 64'(w.centroid_z));
          if (out_if.data.normal_x != w.normal_x)
            report("normal_x", 64'(out_if.data.normal_x), 64'(w.normal_x));
          if (out_if.data.normal_y != w.normal_y)
            report("normal_y", 64'(out_if.data.normal_y), 64'(w.normal_y));
          if (out_if.data.normal_z != w.normal_z)
            report("normal_z", 64'(out_if.data.normal_z), 64'(w.normal_z));
          if (out_if.data.panel_area != w.panel_area)
            report("panel_area", 64'(out_if.data.panel_area), 64'(w.panel_area));
          if (out_if.data.total_area != w.total_area)
            report("total_area", 64'(out_if.data.total_area), 64'(w.total_area));
          if (out_if.data.degenerate != w.degenerate)
            report("degenerate", 64'(out_if.data.degenerate), 64'(w.degenerate));
        end
      end
      if (in_if.valid && in_if.ready) take_point(in_if.data);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("quad_mesh_panel_geometry_test: FAIL");
      $finish;
    end
  end

  function automatic logic [23:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'h800000;
    if (r < 10) return 24'h7FFFFF;
    if (r < 13) return 24'h000000;
    if (r < 40) return 24'($signed($urandom_range(0, 8191)) - 4096);
    return 24'($urandom);
  endfunction

  // queue one mesh; the first point always restarts the mesh, so the line
  // buffer is fully rewritten before any panel reads it
  task automatic add_mesh(int lines, int pts, mesh_kind_e kind);
    qmpg_pkg::point_t p;
    logic [23:0] sx, sy, sz;
    int step;
    sx = pick_coord(); sy = pick_coord(); sz = pick_coord();
    step = $urandom_range(1, 64);
    for (int i = 0; i < lines; i++) begin
      for (int j = 0; j < pts; j++) begin
        case (kind)
          MESH_RANDOM: begin
            p.point_x = pick_coord(); p.point_y = pick_coord(); p.point_z = pick_coord();
          end
          MESH_GRID: begin
            p.point_x = 24'(j * step + $urandom_range(0, 3));
            p.point_y = 24'(i * step + $urandom_range(0, 3));
            p.point_z = 24'($urandom_range(0, 7));
          end
          default: begin
            p.point_x = sx; p.point_y = sy; p.point_z = sz;
          end
        endcase
        p.mesh_start = (i == 0 && j == 0);
        point_queue.push_back(p);
        queued++;
      end
    end
  endtask

  // wait until every point is taken and every panel checked, then let the
  // block finish whatever point it may still be chewing on
  task automatic settle();
    while (point_queue.size() > 0 || in_if.valid || panel_queue.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [qmpg_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[qmpg_pkg::CFG_W-1:0];
    case (idx)
      qmpg_pkg::CFG_POINTS_PER_LINE: line_len = val[10:0];
      qmpg_pkg::CFG_REVERSE_NORMALS: flip_normals = val[0];
      default:                       min_area = val & AREA_MAX;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int eff_len();
    if (line_len < 2) return 2;
    if (line_len > LINE_PTS) return LINE_PTS;
    return line_len;
  endfunction

  initial begin
    int plen;
    int part;
    logic [63:0] thr;
    qmpg_pkg::point_t p;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = qmpg_pkg::CFG_POINTS_PER_LINE;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    foreach (row_x[k]) begin
      row_x[k] = 0; row_y[k] = 0; row_z[k] = 0;
    end
    prev_x = 0; prev_y = 0; prev_z = 0;
    col_cnt = 0; line_cnt = 0; area_total = 0;
    line_len = 11'd2; flip_normals = 1'b0; min_area = 64'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: corners at the coordinate extremes, then random
    for (int k = 0; k < 6; k++) begin
      p.point_x = (k % 2) ? 24'h7FFFFF : 24'h800000;
      p.point_y = (k / 2 == 1) ? 24'h7FFFFF : 24'h800000;
      p.point_z = (k > 3) ? 24'h7FFFFF : 24'h800000;
      p.mesh_start = (k == 0);
      point_queue.push_back(p);
      queued++;
    end
    add_mesh(3, 2, MESH_RANDOM);
    settle();  // sender holds off until every panel is back

    // short line code acts as two, reversed normals, zero threshold:
    // coincident points give a zero cross product that is not flagged
    write_reg(qmpg_pkg::CFG_POINTS_PER_LINE, 64'd0);
    write_reg(qmpg_pkg::CFG_REVERSE_NORMALS, 64'd1);
    write_reg(qmpg_pkg::CFG_AREA_THRESHOLD, 64'd0);
    add_mesh(2, 2, MESH_POINT);
    add_mesh(3, 2, MESH_RANDOM);
    settle();

    // top threshold: every panel degenerate, area still summed
    write_reg(qmpg_pkg::CFG_POINTS_PER_LINE, 64'd1);
    write_reg(qmpg_pkg::CFG_AREA_THRESHOLD, AREA_MAX);
    add_mesh(2, 3, MESH_RANDOM);
    settle();

    // random phases
    while (queued < ITEM_GOAL) begin
      if ($urandom_range(0, 9) < 8) plen = $urandom_range(2, 9);
      else plen = $urandom_range(10, 40);
      write_reg(qmpg_pkg::CFG_POINTS_PER_LINE, 64'(plen));
      write_reg(qmpg_pkg::CFG_REVERSE_NORMALS, 64'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
        0: thr = 64'd0;
        1: thr = 64'd1;
        2: thr = AREA_MAX;
        default: thr = {$urandom, $urandom} >> $urandom_range(15, 60);
      endcase
      write_reg(qmpg_pkg::CFG_AREA_THRESHOLD, thr);
      calm = ($urandom_range(0, 4) == 0);
      for (int m = 0; m < 4 && queued < ITEM_GOAL; m++) begin
        int lines;
        int kind_pick;
        lines = $urandom_range(1, 6);
        while (lines > 1 && queued + lines * eff_len() > ITEM_GOAL) lines--;
        kind_pick = $urandom_range(0, 9);
        add_mesh(lines, eff_len(),
                 kind_pick < 6 ? MESH_RANDOM : (kind_pick < 9 ? MESH_GRID : MESH_POINT));
        // broken sequence: a stray partial line that a restart cuts short
        if ($urandom_range(0, 3) == 0) begin
          part = $urandom_range(1, eff_len());
          add_mesh(1, part, MESH_RANDOM);
        end
      end
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("quad_mesh_panel_geometry_test: PASS");
    end else begin
      $display("quad_mesh_panel_geometry_test: FAIL");
    end
    $finish;
  end

endmodule

@@ quad_mesh_panel_geometry.f @@
+incdir+design
design/qmpg_pkg.sv
design/qmpg_if.sv
design/qmpg_ram.sv
design/qmpg_ctrl.sv
design/qmpg_dp.sv
design/quad_mesh_panel_geometry.sv
verif/quad_mesh_panel_geometry_test.sv
